[src/csrspmv_pkg.sv]
// Shared types and constants for the CSR sparse matrix-vector row engine.
`default_nettype none

package csrspmv_pkg;

    localparam int unsigned VECTOR_DEPTH_DEFAULT = 1024;
    localparam int unsigned IDX_W                = 10;
    localparam int unsigned VAL_W                = 32;
    localparam int unsigned PROD_W               = 2 * VAL_W;
    localparam int unsigned ACC_W                = 48;
    localparam int unsigned FRAC_W               = 16;
    localparam int unsigned FILL_W               = 2;
    localparam int unsigned OP_W                 = 2;
    localparam int unsigned QUEUE_DEPTH          = 4;

    localparam logic [FILL_W-1:0] FILL_WHOLE = 2'd0;
    localparam logic [FILL_W-1:0] FILL_UPPER = 2'd1;
    localparam logic [FILL_W-1:0] FILL_LOWER = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_NONZERO = 2'd1,
        OP_END_ROW = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_MAC  = 2'd1,
        CMD_END  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic [IDX_W-1:0]         addr;
        logic signed [VAL_W-1:0]  data;
        logic [IDX_W-1:0]         row;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

[src/csrspmv_ifs.sv]
// Valid/ready channel interfaces for input items and row results.
`default_nettype none

interface csrspmv_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [9:0]         x_index;
    logic signed [31:0] x_value;
    logic [9:0]         column;
    logic signed [31:0] coefficient;
    logic               before_diagonal;

    modport source (
        output valid, operation, x_index, x_value, column, coefficient, before_diagonal,
        input  ready
    );
    modport sink (
        input  valid, operation, x_index, x_value, column, coefficient, before_diagonal,
        output ready
    );
endinterface

interface csrspmv_out_if;
    logic               valid;
    logic               ready;
    logic [9:0]         row_index;
    logic signed [31:0] y_value;
    logic               saturated;

    modport source (
        output valid, row_index, y_value, saturated,
        input  ready
    );
    modport sink (
        input  valid, row_index, y_value, saturated,
        output ready
    );
endinterface

`default_nettype wire

[src/csr_spmv_triangle_select.sv]
// Top level of the CSR sparse matrix-vector row engine with triangle select.
//
//  channel   dir  handshake          beat contents
//  items     in   valid/ready        operation, x_index, x_value, column,
//                                    coefficient, before_diagonal
//  rows      out  valid/ready        row_index, y_value, saturated
//  cfg       in   cfg_write strobe   fill_mode (cfg_data)
//
// One input beat per cycle while the queue is not full; the front end feeds
// a four-entry queue. After the edge that accepts its end-of-row beat, a row
// result goes through queue slot, x store read, product and output registers.
// Reset clears queue, pipeline valids, accumulator, row counter and fill mode;
// the x store is not cleared. An output stall freezes the back end; the front
// keeps taking beats until the queue fills.
`default_nettype none

module csr_spmv_triangle_select #(
    parameter int unsigned VECTOR_DEPTH = csrspmv_pkg::VECTOR_DEPTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [csrspmv_pkg::FILL_W-1:0] cfg_data,
    csrspmv_in_if.sink                          items,
    csrspmv_out_if.source                       rows
);
    import csrspmv_pkg::*;

    logic          push;
    cmd_t          push_cmd;
    logic          pop;
    cmd_t          head;
    queue_status_t q_status;

    csrspmv_front #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .items     (items),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    csrspmv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    csrspmv_back #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .rows     (rows)
    );

endmodule

`default_nettype wire

[src/csrspmv_front.sv]
// Front end: accepts input beats, applies the fill mode, tracks the row counter.
`default_nettype none

module csrspmv_front #(
    parameter int unsigned VECTOR_DEPTH = csrspmv_pkg::VECTOR_DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [csrspmv_pkg::FILL_W-1:0] cfg_data,
    csrspmv_in_if.sink                         items,
    input  wire csrspmv_pkg::queue_status_t    q_status,
    output logic                               push,
    output csrspmv_pkg::cmd_t                  push_cmd
);
    import csrspmv_pkg::*;

    localparam int unsigned ADDR_W = $clog2(VECTOR_DEPTH);
    localparam int unsigned CMP_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

    logic [FILL_W-1:0] fill_mode_reg;
    logic [IDX_W-1:0]  row_counter_reg;
    logic [IDX_W-1:0]  row_counter_next;
    logic              accept;
    logic              take;
    logic              keep;
    logic [CMP_W-1:0]  idx_ext;

    assign items.ready = !q_status.full;
    assign accept      = items.valid && items.ready;

    always_comb
    begin
        unique case (fill_mode_reg)
            FILL_UPPER: take = !items.before_diagonal;
            FILL_LOWER: take = items.before_diagonal;
            default:    take = 1'b1;
        endcase
    end

    always_comb
    begin
        keep             = 1'b0;
        row_counter_next = row_counter_reg;
        idx_ext          = CMP_W'(items.x_index);
        push_cmd.kind    = CMD_LOAD;
        push_cmd.addr    = items.x_index;
        push_cmd.data    = items.x_value;
        push_cmd.row     = row_counter_reg;
        unique case (items.operation)
            OP_LOAD:
            begin
                keep             = (idx_ext < CMP_W'(VECTOR_DEPTH));
                row_counter_next = '0;
            end
            OP_NONZERO:
            begin
                idx_ext       = CMP_W'(items.column);
                push_cmd.kind = CMD_MAC;
                push_cmd.addr = items.column;
                push_cmd.data = items.coefficient;
                keep          = take && (idx_ext < CMP_W'(VECTOR_DEPTH));
            end
            OP_END_ROW:
            begin
                push_cmd.kind    = CMD_END;
                keep             = 1'b1;
                row_counter_next = row_counter_reg + IDX_W'(1);
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = accept && keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_mode_reg   <= FILL_WHOLE;
            row_counter_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                fill_mode_reg <= cfg_data;
            end
            if (accept)
            begin
                row_counter_reg <= row_counter_next;
            end
        end
    end

endmodule

`default_nettype wire

[src/csrspmv_queue.sv]
// Short command queue between front end and back end.
`default_nettype none

module csrspmv_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire csrspmv_pkg::cmd_t      push_cmd,
    input  wire logic                   pop,
    output csrspmv_pkg::cmd_t           head,
    output csrspmv_pkg::queue_status_t  status
);
    import csrspmv_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count did not follow a push");
`endif

endmodule

`default_nettype wire

[src/csrspmv_back.sv]
// Back end: x store, multiply, 48-bit accumulate and saturating row output.
`default_nettype none

module csrspmv_back #(
    parameter int unsigned VECTOR_DEPTH = csrspmv_pkg::VECTOR_DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire csrspmv_pkg::cmd_t          head,
    input  wire csrspmv_pkg::queue_status_t q_status,
    output logic                            pop,
    csrspmv_out_if.source                   rows
);
    import csrspmv_pkg::*;

    localparam int unsigned ADDR_W = $clog2(VECTOR_DEPTH);
    localparam int unsigned CMP_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

    logic [VAL_W-1:0]         x_mem [VECTOR_DEPTH];
    logic [CMP_W-1:0]         addr_ext;
    logic [ADDR_W-1:0]        mem_addr;
    logic                     advance;

    logic                     s1_valid_reg;
    logic                     s1_end_reg;
    logic signed [VAL_W-1:0]  s1_coef_reg;
    logic signed [VAL_W-1:0]  s1_x_reg;
    logic [IDX_W-1:0]         s1_row_reg;

    logic                     s2_valid_reg;
    logic                     s2_end_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic signed [PROD_W-1:0] s2_prod_next;
    logic [IDX_W-1:0]         s2_row_reg;

    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic                     clip;
    logic signed [VAL_W-1:0]  y_next;

    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_row_reg;
    logic signed [VAL_W-1:0]  out_y_reg;
    logic                     out_sat_reg;

    assign advance  = !out_valid_reg || rows.ready;
    assign pop      = advance && !q_status.empty;
    assign addr_ext = CMP_W'(head.addr);
    assign mem_addr = addr_ext[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (head.kind == CMD_LOAD)
            begin
                x_mem[mem_addr] <= head.data;
            end
            s1_x_reg <= x_mem[mem_addr];
        end
    end

    assign s2_prod_next = PROD_W'(s1_coef_reg) * PROD_W'(s1_x_reg);

    always_comb
    begin
        acc_next = acc_reg + s2_prod_reg[PROD_W-1:FRAC_W];
        if (s2_end_reg)
        begin
            acc_next = '0;
        end
    end

    // Clip when the top bits down to and including the 32-bit sign bit disagree
    always_comb
    begin
        clip   = (acc_reg[ACC_W-1:VAL_W-1] != '0) && (acc_reg[ACC_W-1:VAL_W-1] != '1);
        y_next = acc_reg[VAL_W-1:0];
        if (clip)
        begin
            y_next = acc_reg[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_coef_reg <= head.data;
            s1_row_reg  <= head.row;
            s1_end_reg  <= (head.kind == CMD_END);
            s2_prod_reg <= s2_prod_next;
            s2_row_reg  <= s1_row_reg;
            s2_end_reg  <= s1_end_reg;
            if (s2_valid_reg && s2_end_reg)
            begin
                out_row_reg <= s2_row_reg;
                out_y_reg   <= y_next;
                out_sat_reg <= clip;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= pop && (head.kind != CMD_LOAD);
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_end_reg;
            if (s2_valid_reg)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign rows.valid     = out_valid_reg;
    assign rows.row_index = out_row_reg;
    assign rows.y_value   = out_y_reg;
    assign rows.saturated = out_sat_reg;

`ifndef ASSERT_OFF
    a_end_gives_row: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s2_valid_reg && s2_end_reg |=> out_valid_reg)
        else $error("end of row beat produced no result");
    a_end_clears_acc: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s2_valid_reg && s2_end_reg |=> acc_reg == '0)
        else $error("accumulator not cleared after end of row");
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rows.ready |=> $stable(acc_reg) && $stable(s2_valid_reg))
        else $error("back end moved while output stalled");
`endif

endmodule

`default_nettype wire
